FILE: design/crs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_pkg
// Shared types and constants for the chunk run sorter.
// ----------------------------------------------------------------------------
package crs_pkg;

    // Element width is fixed by the payload format
    localparam int ELEM_W      = 32;
    // Default maximum run length (buffer depth)
    localparam int MAX_RUN_DEF = 32;
    // Width of the run_length register
    localparam int LEN_W       = 6;

    // Register map (byte address = 4 * index)
    localparam int  REG_IDX_W      = 1;
    localparam logic [REG_IDX_W-1:0] REG_RUN_LENGTH = 1'b0;

    // Input transaction payload
    typedef struct packed {
        logic [ELEM_W-1:0] element;
        logic              end_of_data;
    } t_in_item;

    // Output transaction payload
    typedef struct packed {
        logic [ELEM_W-1:0] sorted_element;
        logic              run_end;
        logic              data_end;
    } t_out_item;

endpackage

FILE: design/crs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crs_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/chunk_run_sorter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chunk_run_sorter
// Run formation for an external merge sort: collects elements into runs of
// the configured length and emits each run in ascending order.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Payload
//  --------  ----------------------------------------  ---------  ----------
//  in        i_in_valid / o_in_ready / i_in_data       sink       t_in_item
//  out       o_out_valid / i_out_ready / o_out_data    source     t_out_item
//  config    psel penable pwrite paddr pwdata prdata   slave      run_length
//
//  Each element is inserted into the sorted run buffer as it arrives, one
//  compare-and-shift step at a time through the single RAM read port; into
//  an empty run it is written directly. A closing element then drains the
//  run, reading each result into the output register and holding it while
//  i_out_ready is low. The input is held off during insertion and drain.
//  Reset is synchronous; the run buffer is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module chunk_run_sorter #(
    parameter int MAX_RUN = crs_pkg::MAX_RUN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  crs_pkg::t_in_item    i_in_data,

    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output crs_pkg::t_out_item   o_out_data,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
    localparam int CW = $clog2(MAX_RUN + 1);
    localparam int EW = (CW > crs_pkg::LEN_W) ? CW : crs_pkg::LEN_W;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_CMP   = 6'b000100,
        ST_PUT   = 6'b001000,
        ST_DREAD = 6'b010000,
        ST_DSEND = 6'b100000
    } t_state;

    // Sequencer and control registers
    t_state                      r_state, n_state;
    logic [CW-1:0]               r_fill, n_fill;
    logic [crs_pkg::LEN_W-1:0]   r_run_length;
    logic                        r_out_valid, n_out_valid;
    logic                        r_load, n_load;

    // Payload registers
    logic [AW-1:0]               r_idx, n_idx;
    logic [crs_pkg::ELEM_W-1:0]  r_val, n_val;
    logic                        r_last, n_last;
    logic                        r_flush, n_flush;
    crs_pkg::t_out_item          r_out, n_out;

    // RAM port signals
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [crs_pkg::ELEM_W-1:0]  ram_wdata;
    logic [AW-1:0]               ram_raddr;
    logic [crs_pkg::ELEM_W-1:0]  ram_rdata;

    logic [EW-1:0]               eff_len;
    logic [EW-1:0]               rl_ext;
    logic [EW-1:0]               new_cnt;
    logic [AW-1:0]               last_idx;
    logic                        cfg_wr;
    logic                        cfg_sel;

    crs_ram #(
        .WIDTH (crs_pkg::ELEM_W),
        .DEPTH (MAX_RUN)
    ) u_run_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Effective run length: zero acts as one, saturate at buffer depth
    assign rl_ext  = EW'(r_run_length);
    assign eff_len = (rl_ext == '0) ? EW'(1)
                   : ((rl_ext > EW'(MAX_RUN)) ? EW'(MAX_RUN) : rl_ext);
    assign new_cnt = EW'(r_fill) + EW'(1);
    assign last_idx = AW'(r_fill - CW'(1));

    // Configuration port
    assign cfg_sel = (paddr[2] == crs_pkg::REG_RUN_LENGTH);
    assign cfg_wr  = psel && penable && pwrite && cfg_sel;
    assign pready  = 1'b1;
    assign prdata  = cfg_sel ? 32'(r_run_length) : 32'd0;

    // Sequencer: insertion step, then drain
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_out_valid = r_out_valid;
        n_load      = 1'b0;
        n_idx       = r_idx;
        n_val       = r_val;
        n_last      = r_last;
        n_flush     = r_flush;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = r_val;
        ram_raddr   = r_idx - AW'(1);

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_val   = i_in_data.element;
                    n_last  = i_in_data.end_of_data;
                    n_idx   = r_fill[AW-1:0];
                    n_fill  = r_fill + CW'(1);
                    n_flush = (new_cnt >= eff_len) || i_in_data.end_of_data;
                    n_state = (r_fill == '0) ? ST_PUT : ST_READ;
                end
            end
            ST_READ: begin
                ram_raddr = r_idx - AW'(1);
                n_state   = ST_CMP;
            end
            ST_CMP: begin
                ram_we = 1'b1;
                if (ram_rdata > r_val) begin
                    // shift the larger neighbor up one slot
                    ram_wdata = ram_rdata;
                    n_idx     = r_idx - AW'(1);
                    n_state   = (r_idx == AW'(1)) ? ST_PUT : ST_READ;
                end else begin
                    ram_wdata = r_val;
                    n_idx     = '0;
                    n_state   = r_flush ? ST_DREAD : ST_IDLE;
                end
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_wdata = r_val;
                n_idx     = '0;
                n_state   = r_flush ? ST_DREAD : ST_IDLE;
            end
            ST_DREAD: begin
                ram_raddr = r_idx;
                n_load    = 1'b1;
                n_state   = ST_DSEND;
            end
            ST_DSEND: begin
                if (r_load) begin
                    // read data lands in the output register
                    n_out.sorted_element = ram_rdata;
                    n_out.run_end        = (r_idx == last_idx);
                    n_out.data_end       = (r_idx == last_idx) && r_last;
                    n_out_valid          = 1'b1;
                end else if (r_out_valid && i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.run_end) begin
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_DREAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
            r_load       <= 1'b0;
            r_run_length <= crs_pkg::LEN_W'(MAX_RUN);
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_load      <= n_load;
            if (cfg_wr) begin
                r_run_length <= pwdata[crs_pkg::LEN_W-1:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_val   <= n_val;
        r_last  <= n_last;
        r_flush <= n_flush;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: tb/crs_run_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crs_run_checker
// Passive checker for the chunk run sorter: it follows the register writes
// and every accepted input transaction, keeps its own sorted copy of the run
// being collected, queues the sorted results that each closing element
// releases, and compares every output transaction field by field against
// the oldest queued result. Register reads are checked against the tracked
// run length.
// ----------------------------------------------------------------------------
module crs_run_checker
    import crs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in_item    i_in_data,

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out_item   i_out_data,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,

    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Elements of the open run, always kept in ascending order
    logic [ELEM_W-1:0] run_sorted [MAX_RUN_DEF];
    int                held_count;
    logic [LEN_W-1:0]  run_length_reg;
    // Sorted results still to come out of the block
    t_out_item         sorted_results [$];

    // Zero behaves as one, anything above the buffer depth saturates
    function automatic int closing_length(input logic [LEN_W-1:0] len);
        if (len == '0)
            return 1;
        if (int'(len) > MAX_RUN_DEF)
            return MAX_RUN_DEF;
        return int'(len);
    endfunction

    function automatic logic reg_hit(input logic [2:0] addr);
        return (addr[2] == REG_RUN_LENGTH) && (addr[1:0] == 2'b00);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    always @(posedge i_clk) begin : track
        int        pos;
        t_out_item want;
        t_out_item emit;

        if (!i_rst_n) begin
            held_count     = 0;
            run_length_reg = LEN_W'(MAX_RUN_DEF);
            sorted_results.delete();
        end else begin
            // Register writes and read-back
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (reg_hit(paddr))
                        run_length_reg = pwdata[LEN_W-1:0];
                end else if (reg_hit(paddr) && prdata !== 32'(run_length_reg)) begin
                    $error("run_length read: expected %0d, actual %0d",
                           run_length_reg, prdata);
                    o_fail_count++;
                end
            end

            // Output transaction against the oldest expected result
            if (i_out_valid && i_out_ready) begin
                if (sorted_results.size() == 0) begin
                    $error("unexpected result: sorted_element=%h run_end=%b data_end=%b",
                           i_out_data.sorted_element, i_out_data.run_end,
                           i_out_data.data_end);
                    o_fail_count++;
                end else begin
                    want = sorted_results.pop_front();
                    o_checked++;
                    if (i_out_data.sorted_element !== want.sorted_element) begin
                        $error("sorted_element: expected %h, actual %h",
                               want.sorted_element, i_out_data.sorted_element);
                        o_fail_count++;
                    end
                    if (i_out_data.run_end !== want.run_end) begin
                        $error("run_end: expected %b, actual %b",
                               want.run_end, i_out_data.run_end);
                        o_fail_count++;
                    end
                    if (i_out_data.data_end !== want.data_end) begin
                        $error("data_end: expected %b, actual %b",
                               want.data_end, i_out_data.data_end);
                        o_fail_count++;
                    end
                end
            end

            // Input transaction: insert in place, release the run when it closes
            if (i_in_valid && i_in_ready) begin
                if (held_count >= MAX_RUN_DEF)
                    held_count = 0;
                pos = held_count;
                while (pos > 0 && run_sorted[pos-1] > i_in_data.element) begin
                    run_sorted[pos] = run_sorted[pos-1];
                    pos--;
                end
                run_sorted[pos] = i_in_data.element;
                held_count++;

                if (held_count >= closing_length(run_length_reg) || i_in_data.end_of_data)
                begin
                    for (int k = 0; k < held_count; k++) begin
                        emit.sorted_element = run_sorted[k];
                        emit.run_end        = (k == held_count - 1);
                        emit.data_end       = (k == held_count - 1) && i_in_data.end_of_data;
                        sorted_results.push_back(emit);
                    end
                    held_count = 0;
                end
            end
        end
        o_pending <= sorted_results.size();
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the chunk run sorter. A directed part covers
// extreme element values, equal elements, run lengths of zero, one and
// above the buffer depth, a write to an unmapped address and a run length
// lowered while a run is partly full. Random phases then stream elements at
// several run lengths with random input gaps and output stalls, while the
// checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import crs_pkg::*;

    localparam int         IDLE_CYCLES     = 2 * MAX_RUN_DEF + 16;
    localparam int         CYCLE_LIMIT     = 400000;
    localparam logic [2:0] RUN_LENGTH_ADDR = {REG_RUN_LENGTH, 2'b00};
    localparam logic [2:0] UNMAPPED_ADDR   = 3'd4;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data   = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int checked;
    int items_sent    = 0;
    int settings_used = 0;
    int cycle_count   = 0;
    int ready_left    = 0;
    logic steady_input = 1'b0;

    chunk_run_sorter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    crs_run_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Output backpressure: mostly short ready and stall spells, some long ones of each
    always @(posedge i_clk) begin : out_stall
        int pick;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            ready_left  <= 0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                i_out_ready <= 1'b1;
                ready_left  <= $urandom_range(0, 6);
            end else if (pick < 65) begin
                i_out_ready <= 1'b1;
                ready_left  <= $urandom_range(30, 80);
            end else if (pick < 95) begin
                i_out_ready <= 1'b0;
                ready_left  <= $urandom_range(0, 3);
            end else begin
                i_out_ready <= 1'b0;
                ready_left  <= $urandom_range(10, 40);
            end
        end
    end

    function automatic int input_gap();
        int pick;
        if (steady_input)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Extremes, small values for duplicates, single high bit, full range
    function automatic logic [ELEM_W-1:0] random_element();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return '0;
            1:       return '1;
            2, 3:    return ELEM_W'($urandom_range(0, 7));
            4:       return ELEM_W'(1) << $urandom_range(0, ELEM_W - 1);
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    // One input transaction, after an optional gap with valid low
    task automatic send_element(input logic [ELEM_W-1:0] value, input logic last);
        int gap;
        gap = input_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{element: value, end_of_data: last};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    // Setup and access cycles; ends in the cycle after the bus is released
    task automatic apb_access(input logic write, input logic [2:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Set run_length and read it back
    task automatic set_run_length(input logic [31:0] word);
        apb_access(1'b1, RUN_LENGTH_ADDR, word);
        apb_access(1'b0, RUN_LENGTH_ADDR, '0);
        settings_used++;
    endtask

    // Drop valid, wait for every result, then let any insertion finish
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(input logic [31:0] word, input int count,
                                input int eod_odds, input logic steady);
        logic last;
        wait_idle();
        set_run_length(word);
        steady_input = steady;
        for (int i = 0; i < count; i++) begin
            last = ($urandom_range(1, eod_odds) == 1) || (i == count - 1);
            send_element(random_element(), last);
        end
        steady_input = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of run_length
        apb_access(1'b0, RUN_LENGTH_ADDR, '0);

        // Full run of four with extreme values
        set_run_length(32'd4);
        send_element('1, 1'b0);
        send_element('0, 1'b0);
        send_element(32'h8000_0000, 1'b0);
        send_element(32'h7FFF_FFFF, 1'b0);
        // Equal elements, partial run flushed by end of data
        send_element(32'd5, 1'b0);
        send_element(32'd5, 1'b0);
        send_element(32'd5, 1'b1);
        wait_idle();

        // Zero acts as one: every element is its own run
        set_run_length(32'd0);
        send_element(32'hAAAA_AAAA, 1'b0);
        send_element(32'h5555_5555, 1'b1);
        wait_idle();
        set_run_length(32'd1);
        send_element(32'h1234_5678, 1'b0);
        wait_idle();

        // Unmapped address leaves run_length alone
        apb_access(1'b1, UNMAPPED_ADDR, 32'd2);
        apb_access(1'b0, RUN_LENGTH_ADDR, '0);

        // Run length lowered below the count already held
        set_run_length(32'd10);
        send_element(32'd9, 1'b0);
        send_element(32'd3, 1'b0);
        send_element(32'd7, 1'b0);
        send_element(32'd1, 1'b0);
        wait_idle();
        set_run_length(32'd3);
        send_element(32'd4, 1'b0);
        wait_idle();

        // Above the buffer depth, with junk in the upper write bits
        set_run_length({26'($urandom() >> LEN_W), 6'd63});
        send_element(32'hFFFF_FFFE, 1'b0);
        send_element(32'd2, 1'b0);
        send_element(32'hFFFF_FFFE, 1'b1);

        // Random phases over a spread of run lengths
        random_phase(32'd32, 36, 50, 1'b0);
        random_phase(32'd1, 6, 6, 1'b1);
        random_phase(32'd2, 8, 8, 1'b0);
        random_phase(32'($urandom_range(3, 31)), 10, 10, 1'b0);
        random_phase(32'd0, 6, 6, 1'b0);
        random_phase({26'($urandom() >> LEN_W), 6'($urandom_range(33, 63))}, 36, 60, 1'b1);
        random_phase(32'($urandom_range(1, 32)), 10, 12, 1'b0);

        wait_idle();
        $display("Sent %0d elements under %0d run length settings; checked %0d sorted results.",
                 items_sent, settings_used, checked);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
design/crs_pkg.sv
design/crs_ram.sv
design/chunk_run_sorter.sv
tb/crs_run_checker.sv
tb/tb.sv
